// ----- rtl/core/dda_pkg.sv -----
// Package for the DDA dash/dot line stepper: fixed widths, register and
// opcode codes, and the command/status structs between controller and datapath.
// No dependencies.
package dda_pkg;

    // Configuration register widths and reset values
    localparam int MASK_BITS      = 9;
    localparam int COLOR_BITS     = 4;
    localparam int CFG_DATA_BITS  = 9;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [MASK_BITS-1:0]  MASK_RESET  = 9'd380;
    localparam logic [COLOR_BITS-1:0] COLOR_RESET = 4'd3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_MASK = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PIXEL_COLOR  = 2'd1;

    // Input item opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // latch a new line, present start point, start divide
        logic step;      // present one sample point and advance
        logic emit_end;  // present the end point of the loaded line
    } dda_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;  // both increment divides finish at this edge
    } dda_sts_t;

endpackage

// ----- rtl/core/dda_dash_dot_line_stepper.sv -----
// Top level of the DDA dash/dot line stepper: ports, packing, and the
// controller/datapath pair. Depends on dda_pkg, dda_ctrl, dda_datapath.
//
//  channel  | signals                         | moves
//  ---------+---------------------------------+-----------------------------
//  s_       | tvalid tready tdata tuser       | load or step item
//  m_       | tvalid tready tdata tuser tlast | one point per transaction
//  cfg_     | valid ready index data          | register write, always ready
//
// Steps stream at one per cycle while m_tready is high. After a load, the next
// item is taken only once the bit-serial increment divide and the end-point
// emit are through.
// Reset is asynchronous and needs no clearing pass. A stalled output holds
// one point; a new item is taken in the cycle that point leaves.
module dda_dash_dot_line_stepper #(
    parameter int COORD_BITS     = 10,
    parameter int FRAC_BITS      = 16,
    parameter int PATTERN_PERIOD = 9,
    localparam int IN_BITS  = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_BITS = ((2 * COORD_BITS + dda_pkg::COLOR_BITS + 7) / 8) * 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [IN_BITS-1:0]                 s_tdata,   // start_x, start_y, end_x, end_y
    input  logic                               s_tuser,   // opcode
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [OUT_BITS-1:0]                m_tdata,   // pixel_x, pixel_y, color
    output logic                               m_tuser,   // plot
    output logic                               m_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dda_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [dda_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    import dda_pkg::*;

    dda_cmd_t              cmd;
    dda_sts_t              sts;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0] color;

    assign cfg_ready = 1'b1;

    dda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dda_datapath #(
        .COORD_BITS     (COORD_BITS),
        .FRAC_BITS      (FRAC_BITS),
        .PATTERN_PERIOD (PATTERN_PERIOD)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start_x   (s_tdata[COORD_BITS-1:0]),
        .start_y   (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .end_x     (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .end_y     (s_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .plot      (m_tuser),
        .color     (color),
        .last      (m_tlast)
    );

    // Pack result fields, zero fill to whole bytes
    assign m_tdata = OUT_BITS'({color, pixel_y, pixel_x});

endmodule

// ----- rtl/core/dda_div.sv -----
// Restoring serial divider: one quotient bit per cycle, unsigned operands.
// Used by dda_datapath for the per-step increments. No package needed.
module dda_div #(
    parameter int DIVIDEND_BITS = 26,
    parameter int DIVISOR_BITS  = 10,
    parameter int QUOT_BITS     = 17
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DIVIDEND_BITS-1:0] dividend,
    input  logic [DIVISOR_BITS-1:0]  divisor,
    output logic                     done,
    output logic [QUOT_BITS-1:0]     quot
);

    localparam int CNT_BITS = $clog2(DIVIDEND_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(DIVIDEND_BITS - 1);

    logic                     busy_reg;
    logic                     busy_next;
    logic [CNT_BITS-1:0]      cnt_reg;
    logic [CNT_BITS-1:0]      cnt_next;
    logic [DIVIDEND_BITS-1:0] work_reg;
    logic [DIVIDEND_BITS-1:0] work_next;
    logic [DIVISOR_BITS-1:0]  rem_reg;
    logic [DIVISOR_BITS-1:0]  rem_next;
    logic [DIVISOR_BITS-1:0]  dsr_reg;
    logic [DIVISOR_BITS:0]    trial;
    logic [DIVISOR_BITS:0]    diff;
    logic                     ge;

    // One restoring iteration
    always_comb
    begin
        trial     = {rem_reg, work_reg[DIVIDEND_BITS-1]};
        diff      = trial - {1'b0, dsr_reg};
        ge        = (trial >= {1'b0, dsr_reg});
        rem_next  = ge ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
        work_next = {work_reg[DIVIDEND_BITS-2:0], ge};
    end

    assign done = busy_reg && (cnt_reg == CNT_LAST);
    assign quot = work_next[QUOT_BITS-1:0];

    // Iteration control
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            busy_next = !done;
            cnt_next  = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and partial remainder registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= dividend;
            rem_reg  <= '0;
            dsr_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg && (cnt_reg == '0))
        else $error("divider did not begin after start");

endmodule

// ----- rtl/core/dda_datapath.sv -----
// Datapath of the line stepper: configuration, line state, increment dividers
// and the output holding register. Depends on dda_pkg and dda_div.
module dda_datapath #(
    parameter int COORD_BITS     = 10,
    parameter int FRAC_BITS      = 16,
    parameter int PATTERN_PERIOD = 9
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  dda_pkg::dda_cmd_t                    cmd,
    output dda_pkg::dda_sts_t                    sts,
    input  logic                                 cfg_we,
    input  logic [dda_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [dda_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic [COORD_BITS-1:0]                start_x,
    input  logic [COORD_BITS-1:0]                start_y,
    input  logic [COORD_BITS-1:0]                end_x,
    input  logic [COORD_BITS-1:0]                end_y,
    output logic [COORD_BITS-1:0]                pixel_x,
    output logic [COORD_BITS-1:0]                pixel_y,
    output logic                                 plot,
    output logic [dda_pkg::COLOR_BITS-1:0]       color,
    output logic                                 last
);

    import dda_pkg::*;

    localparam int POS_BITS   = COORD_BITS + FRAC_BITS + 1;
    localparam int INC_BITS   = FRAC_BITS + 2;
    localparam int QUOT_BITS  = FRAC_BITS + 1;
    localparam int DVD_BITS   = COORD_BITS + FRAC_BITS;
    localparam int PH_BITS    = $clog2(PATTERN_PERIOD);
    localparam int PH_LUT     = 16;
    localparam logic [PH_BITS-1:0] PH_LAST = PH_BITS'(PATTERN_PERIOD - 1);

    // Configuration registers
    logic [MASK_BITS-1:0]  pattern_mask_reg;
    logic [COLOR_BITS-1:0] pixel_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_mask_reg <= MASK_RESET;
            pixel_color_reg  <= COLOR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PATTERN_MASK: pattern_mask_reg <= cfg_data[MASK_BITS-1:0];
                CFG_PIXEL_COLOR:  pixel_color_reg  <= cfg_data[COLOR_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // Endpoint deltas and major-axis length
    logic [COORD_BITS:0]   dx;
    logic [COORD_BITS:0]   dy;
    logic [COORD_BITS:0]   ndx;
    logic [COORD_BITS:0]   ndy;
    logic [COORD_BITS-1:0] ax;
    logic [COORD_BITS-1:0] ay;
    logic [COORD_BITS-1:0] len;

    always_comb
    begin
        dx  = {1'b0, end_x} - {1'b0, start_x};
        dy  = {1'b0, end_y} - {1'b0, start_y};
        ndx = -dx;
        ndy = -dy;
        ax  = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
        ay  = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
        len = (ax >= ay) ? ax : ay;
    end

    // Increment dividers, run side by side
    logic                 done_x;
    logic                 done_y;
    logic [QUOT_BITS-1:0] quot_x;
    logic [QUOT_BITS-1:0] quot_y;

    dda_div #(
        .DIVIDEND_BITS (DVD_BITS),
        .DIVISOR_BITS  (COORD_BITS),
        .QUOT_BITS     (QUOT_BITS)
    ) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.load),
        .dividend ({ax, FRAC_BITS'(0)}),
        .divisor  (len),
        .done     (done_x),
        .quot     (quot_x)
    );

    dda_div #(
        .DIVIDEND_BITS (DVD_BITS),
        .DIVISOR_BITS  (COORD_BITS),
        .QUOT_BITS     (QUOT_BITS)
    ) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.load),
        .dividend ({ay, FRAC_BITS'(0)}),
        .divisor  (len),
        .done     (done_y),
        .quot     (quot_y)
    );

    assign sts.div_done = done_x && done_y;

    // Line state
    logic                  active_reg;
    logic [POS_BITS-1:0]   pos_x_reg;
    logic [POS_BITS-1:0]   pos_y_reg;
    logic [INC_BITS-1:0]   inc_x_reg;
    logic [INC_BITS-1:0]   inc_y_reg;
    logic [COORD_BITS-1:0] step_reg;
    logic [COORD_BITS-1:0] len_reg;
    logic [PH_BITS-1:0]    phase_reg;
    logic                  neg_x_reg;
    logic                  neg_y_reg;
    logic [COORD_BITS-1:0] end_x_reg;
    logic [COORD_BITS-1:0] end_y_reg;

    logic [INC_BITS-1:0]   qx_ext;
    logic [INC_BITS-1:0]   qy_ext;
    logic [INC_BITS-1:0]   inc_x_next;
    logic [INC_BITS-1:0]   inc_y_next;
    logic [POS_BITS-1:0]   pos_x_next;
    logic [POS_BITS-1:0]   pos_y_next;
    logic [COORD_BITS-1:0] pix_x;
    logic [COORD_BITS-1:0] pix_y;
    logic [PH_LUT-1:0]     mask_wide;
    logic                  step_plot;
    logic                  step_last;

    always_comb
    begin
        // Signed increment; zero-length line keeps both increments at zero
        qx_ext     = {1'b0, quot_x};
        qy_ext     = {1'b0, quot_y};
        inc_x_next = neg_x_reg ? -qx_ext : qx_ext;
        inc_y_next = neg_y_reg ? -qy_ext : qy_ext;
        if (len_reg == '0)
        begin
            inc_x_next = '0;
            inc_y_next = '0;
        end
        // Position advance and pixel extraction (negative clamps to zero)
        pos_x_next = pos_x_reg + {{(POS_BITS-INC_BITS){inc_x_reg[INC_BITS-1]}}, inc_x_reg};
        pos_y_next = pos_y_reg + {{(POS_BITS-INC_BITS){inc_y_reg[INC_BITS-1]}}, inc_y_reg};
        pix_x      = pos_x_reg[POS_BITS-1] ? '0 : pos_x_reg[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
        pix_y      = pos_y_reg[POS_BITS-1] ? '0 : pos_y_reg[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
        // Phases past the mask width read as gaps
        mask_wide  = PH_LUT'(pattern_mask_reg);
        step_plot  = mask_wide[4'(phase_reg)];
        step_last  = (step_reg == len_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= 1'b0;
        else if (cmd.load)
            active_reg <= 1'b1;
        else if (cmd.step && active_reg && step_last)
            active_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pos_x_reg <= {1'b0, start_x, 1'b1, (FRAC_BITS-1)'(0)};
            pos_y_reg <= {1'b0, start_y, 1'b1, (FRAC_BITS-1)'(0)};
            step_reg  <= '0;
            phase_reg <= '0;
            len_reg   <= len;
            neg_x_reg <= dx[COORD_BITS];
            neg_y_reg <= dy[COORD_BITS];
            end_x_reg <= end_x;
            end_y_reg <= end_y;
        end
        else if (cmd.step && active_reg)
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            step_reg  <= step_reg + 1'b1;
            phase_reg <= (phase_reg == PH_LAST) ? '0 : phase_reg + 1'b1;
        end
        if (sts.div_done)
        begin
            inc_x_reg <= inc_x_next;
            inc_y_reg <= inc_y_next;
        end
    end

    // Output holding register
    logic [COORD_BITS-1:0] out_x_reg;
    logic [COORD_BITS-1:0] out_y_reg;
    logic                  out_plot_reg;
    logic [COLOR_BITS-1:0] out_color_reg;
    logic                  out_last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_x_reg     <= start_x;
            out_y_reg     <= start_y;
            out_plot_reg  <= 1'b1;
            out_color_reg <= pixel_color_reg;
            out_last_reg  <= 1'b0;
        end
        else if (cmd.emit_end)
        begin
            out_x_reg     <= end_x_reg;
            out_y_reg     <= end_y_reg;
            out_plot_reg  <= 1'b1;
            out_color_reg <= pixel_color_reg;
            out_last_reg  <= 1'b0;
        end
        else if (cmd.step)
        begin
            out_x_reg     <= active_reg ? pix_x : '0;
            out_y_reg     <= active_reg ? pix_y : '0;
            out_plot_reg  <= active_reg && step_plot;
            out_color_reg <= pixel_color_reg;
            out_last_reg  <= !active_reg || step_last;
        end
    end

    assign pixel_x = out_x_reg;
    assign pixel_y = out_y_reg;
    assign plot    = out_plot_reg;
    assign color   = out_color_reg;
    assign last    = out_last_reg;

    a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && !active_reg) |=> (out_last_reg && !out_plot_reg))
        else $error("idle step did not give an unplotted last point");

endmodule

// ----- rtl/core/dda_ctrl.sv -----
// Controller of the line stepper: input/output handshakes and the load
// sequence (divide, then end point). Depends on dda_pkg.
module dda_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              opcode,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  dda_pkg::dda_sts_t sts,
    output dda_pkg::dda_cmd_t cmd
);

    import dda_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_END  = 3'b100
    } dda_state_t;

    dda_state_t state_reg;
    dda_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;
    logic       accept;

    // Output slot is free when empty or being taken this cycle
    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && slot_free;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;

    // Commands
    always_comb
    begin
        cmd.load     = accept && (opcode == OP_LOAD);
        cmd.step     = accept && (opcode == OP_STEP);
        cmd.emit_end = (state_reg == ST_END) && slot_free;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (cmd.load)      state_next = ST_DIV;
            ST_DIV:  if (sts.div_done)  state_next = ST_END;
            ST_END:  if (slot_free)     state_next = ST_IDLE;
            default:                    state_next = ST_IDLE;
        endcase
    end

    // Output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load || cmd.step || cmd.emit_end)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_load_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_DIV))
        else $error("load did not enter the divide state");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> (state_reg == ST_DIV))
        else $error("divide finished outside the divide state");

    a_end_shown: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_end |=> (m_tvalid && (state_reg == ST_IDLE)))
        else $error("end point not presented after emit");

endmodule

// ----- verif/dda_point_checker.sv -----
`timescale 1ns / 100ps
// Point checker for the DDA dash/dot line stepper: watches the input, output
// and register-write channels, predicts every point and compares it on arrival.
// Depends on dda_pkg.
module dda_point_checker
    import dda_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [39:0]               s_tdata,   // start_x, start_y, end_x, end_y
    input  logic                      s_tuser,   // opcode
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [23:0]               m_tdata,   // pixel_x, pixel_y, color
    input  logic                      m_tuser,   // plot
    input  logic                      m_tlast,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output int                        errors,
    output int                        pending,
    output int                        points_seen
);

    localparam int COORD  = 10;
    localparam int FRAC   = 16;
    localparam int PERIOD = 9;

    typedef struct packed {
        logic [COORD-1:0]      x;
        logic [COORD-1:0]      y;
        logic                  plot;
        logic [COLOR_BITS-1:0] color;
        logic                  last;
    } point_t;

    // Register copies
    logic [MASK_BITS-1:0]  mask_q;
    logic [COLOR_BITS-1:0] color_q;

    // Line walker state
    logic signed [26:0] pos_x;
    logic signed [26:0] pos_y;
    logic signed [17:0] inc_x;
    logic signed [17:0] inc_y;
    logic [10:0]        step_idx;
    logic [10:0]        line_len;
    logic [3:0]         phase;
    logic               active;

    point_t expected_points[$];

    // Per-step increment d / len in fixed point, rounded toward zero
    function automatic logic signed [17:0] step_increment(input int delta, input int len);
        int mag;
        int quo;
        if (len == 0)
            return '0;
        mag = (delta < 0) ? -delta : delta;
        quo = (mag << FRAC) / len;
        return 18'((delta < 0) ? -quo : quo);
    endfunction

    // Integer part of a position; negative positions clamp to zero
    function automatic logic [COORD-1:0] pixel_of(input logic signed [26:0] p);
        if (p < 0)
            return '0;
        return p[FRAC+COORD-1:FRAC];
    endfunction

    task automatic predict_points(input logic op, input logic [39:0] d);
        logic [COORD-1:0] sx;
        logic [COORD-1:0] sy;
        logic [COORD-1:0] ex;
        logic [COORD-1:0] ey;
        int               dx;
        int               dy;
        int               ax;
        int               ay;
        int               len;
        point_t           pt;
        logic             is_last;
        sx = d[9:0];
        sy = d[19:10];
        ex = d[29:20];
        ey = d[39:30];
        if (op == OP_LOAD)
        begin
            dx  = int'(ex) - int'(sx);
            dy  = int'(ey) - int'(sy);
            ax  = (dx < 0) ? -dx : dx;
            ay  = (dy < 0) ? -dy : dy;
            len = (ax >= ay) ? ax : ay;
            line_len = 11'(len);
            inc_x    = step_increment(dx, len);
            inc_y    = step_increment(dy, len);
            // start endpoint plus one half for rounding
            pos_x    = (27'(sx) << FRAC) + (27'sd1 << (FRAC - 1));
            pos_y    = (27'(sy) << FRAC) + (27'sd1 << (FRAC - 1));
            step_idx = '0;
            phase    = '0;
            active   = 1'b1;
            expected_points.push_back('{x: sx, y: sy, plot: 1'b1, color: color_q, last: 1'b0});
            expected_points.push_back('{x: ex, y: ey, plot: 1'b1, color: color_q, last: 1'b0});
        end
        else if (!active)
        begin
            // idle step: empty point marked last
            expected_points.push_back('{x: '0, y: '0, plot: 1'b0, color: color_q, last: 1'b1});
        end
        else
        begin
            is_last  = (step_idx >= line_len);
            pt.x     = pixel_of(pos_x);
            pt.y     = pixel_of(pos_y);
            pt.plot  = (phase < MASK_BITS) ? mask_q[phase] : 1'b0;
            pt.color = color_q;
            pt.last  = is_last;
            expected_points.push_back(pt);
            pos_x    = pos_x + inc_x;
            pos_y    = pos_y + inc_y;
            step_idx = step_idx + 1'b1;
            phase    = (phase + 1 >= PERIOD) ? 4'd0 : phase + 1'b1;
            if (is_last)
                active = 1'b0;
        end
    endtask

    task automatic check_point();
        point_t want;
        point_t got;
        got.x     = m_tdata[9:0];
        got.y     = m_tdata[19:10];
        got.color = m_tdata[23:20];
        got.plot  = m_tuser;
        got.last  = m_tlast;
        points_seen++;
        if (expected_points.size() == 0)
        begin
            $error("unexpected point: x %0d y %0d plot %0d color %0d last %0d",
                   got.x, got.y, got.plot, got.color, got.last);
            errors++;
            return;
        end
        want = expected_points.pop_front();
        if (got.x !== want.x)
        begin
            $error("pixel_x: expected %0d, actual %0d", want.x, got.x);
            errors++;
        end
        if (got.y !== want.y)
        begin
            $error("pixel_y: expected %0d, actual %0d", want.y, got.y);
            errors++;
        end
        if (got.plot !== want.plot)
        begin
            $error("plot: expected %0d, actual %0d", want.plot, got.plot);
            errors++;
        end
        if (got.color !== want.color)
        begin
            $error("color: expected %0d, actual %0d", want.color, got.color);
            errors++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            errors++;
        end
    endtask

    // Register writes, then new items, then arriving points
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_q   = MASK_RESET;
            color_q  = COLOR_RESET;
            pos_x    = '0;
            pos_y    = '0;
            inc_x    = '0;
            inc_y    = '0;
            step_idx = '0;
            line_len = '0;
            phase    = '0;
            active   = 1'b0;
            expected_points.delete();
            pending  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PATTERN_MASK: mask_q  = cfg_data[MASK_BITS-1:0];
                    CFG_PIXEL_COLOR:  color_q = cfg_data[COLOR_BITS-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_points(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                check_point();
            pending = expected_points.size();
        end
    end

endmodule

// ----- verif/tb_dda_dash_dot_line_stepper.sv -----
`timescale 1ns / 100ps
// Testbench top for the DDA dash/dot line stepper: clock, reset, stimulus,
// random output stalls and the verdict. Depends on dda_pkg, the DUT and dda_point_checker.
module tb_dda_dash_dot_line_stepper;
    import dda_pkg::*;

    localparam int COORD_MAX = 1023;

    logic                      clk;
    logic                      rst_n;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [39:0]               s_tdata;   // start_x, start_y, end_x, end_y
    logic                      s_tuser;   // opcode
    logic                      m_tvalid;
    logic                      m_tready;
    logic [23:0]               m_tdata;   // pixel_x, pixel_y, color
    logic                      m_tuser;   // plot
    logic                      m_tlast;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    int errors;
    int pending;
    int points_seen;

    bit quiet;
    int items_sent;
    int loads_sent;
    int steps_sent;
    int reg_writes;

    dda_dash_dot_line_stepper dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dda_point_checker u_point_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .pending     (pending),
        .points_seen (points_seen)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run guard
    initial
    begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int near(input int c, input int spread);
        int v;
        v = c + $urandom_range(0, 2 * spread) - spread;
        if (v < 0)
            v = 0;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return v;
    endfunction

    // Output stalls: runs of ready, then random-length stalls
    initial
    begin
        int hold;
        m_tready = 1'b0;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else if (quiet || !m_tready)
            begin
                m_tready <= 1'b1;
                hold = $urandom_range(0, 15);
            end
            else
            begin
                hold = pick_gap();
                if (hold > 0)
                begin
                    m_tready <= 1'b0;
                    hold--;
                end
            end
        end
    end

    // One input transaction; valid stays high on return
    task automatic send_item(input logic op, input int sx, input int sy, input int ex,
                             input int ey);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {10'(ey), 10'(ex), 10'(sy), 10'(sx)};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
        if (op == OP_LOAD)
            loads_sent++;
        else
            steps_sent++;
    endtask

    task automatic send_step();
        send_item(OP_STEP, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                  $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
    endtask

    // Load a line and issue a given number of steps
    task automatic walk_line(input int sx, input int sy, input int ex, input int ey,
                             input int steps);
        send_item(OP_LOAD, sx, sy, ex, ey);
        repeat (steps) send_step();
    endtask

    function automatic int major_len(input int sx, input int sy, input int ex, input int ey);
        int ax;
        int ay;
        ax = (ex > sx) ? ex - sx : sx - ex;
        ay = (ey > sy) ? ey - sy : sy - ey;
        return (ax >= ay) ? ax : ay;
    endfunction

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int value);
        drain();
        // cfg_valid goes low between back-to-back writes
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_BITS'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    // Random traffic: mostly complete lines, some abandoned, noise and degenerate
    task automatic random_phase(input int count);
        int stop_at;
        int r;
        int sx;
        int sy;
        int ex;
        int ey;
        int spread;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            r  = $urandom_range(0, 99);
            sx = $urandom_range(0, COORD_MAX);
            sy = $urandom_range(0, COORD_MAX);
            if (r < 88)
            begin
                spread = (r < 78) ? $urandom_range(1, 20) : $urandom_range(21, 120);
                ex = near(sx, spread);
                ey = near(sy, spread);
                walk_line(sx, sy, ex, ey, major_len(sx, sy, ex, ey) + 1 +
                          (($urandom_range(0, 99) < 15) ? $urandom_range(1, 2) : 0));
            end
            else if (r < 93)
            begin
                // dropped mid-way by the next load
                walk_line(sx, sy, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                          $urandom_range(0, 30));
            end
            else if (r < 97)
            begin
                repeat ($urandom_range(1, 4))
                    send_item(1'($urandom_range(0, 1)), $urandom_range(0, COORD_MAX),
                              $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                              $urandom_range(0, COORD_MAX));
            end
            else
            begin
                // zero-length line
                walk_line(sx, sy, sx, sy, $urandom_range(1, 2));
            end
            if ($urandom_range(0, 99) < 2)
                drain();
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tuser    = OP_LOAD;
        s_tdata    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_PATTERN_MASK;
        cfg_data   = '0;
        quiet      = 1'b0;
        items_sent = 0;
        loads_sent = 0;
        steps_sent = 0;
        reg_writes = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: idle step, zero-length line, corner lines, reload while active
        send_step();
        walk_line(5, 5, 5, 5, 2);
        walk_line(0, 0, COORD_MAX, COORD_MAX, 3);
        walk_line(COORD_MAX, COORD_MAX, 0, 0, 3);
        walk_line(COORD_MAX, 0, 0, COORD_MAX, 2);
        walk_line(3, 7, 10, 2, 9);

        // Random phases across register settings
        random_phase(250);
        write_reg(CFG_PATTERN_MASK, 0);
        write_reg(CFG_PIXEL_COLOR, 15);
        random_phase(200);
        write_reg(CFG_PATTERN_MASK, 511);
        write_reg(CFG_PIXEL_COLOR, 0);
        quiet = 1'b1;
        random_phase(200);
        quiet = 1'b0;
        // indexes past the register list are dropped
        write_reg(2'(CFG_PIXEL_COLOR + 1), $urandom_range(0, 511));
        write_reg(2'(CFG_PIXEL_COLOR + 2), $urandom_range(0, 511));
        random_phase(150);
        repeat (4)
        begin
            write_reg(CFG_PATTERN_MASK, $urandom_range(0, 511));
            write_reg(CFG_PIXEL_COLOR, $urandom_range(0, 15));
            random_phase(150);
        end

        // Drain and let any stray output show up
        drain();
        repeat (40) @(posedge clk);
        $display("Sent %0d loads and %0d steps over %0d register writes;", loads_sent,
                 steps_sent, reg_writes);
        $display("checked %0d points, %0d mismatches.", points_seen, errors);
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/dda_pkg.sv
rtl/core/dda_div.sv
rtl/core/dda_datapath.sv
rtl/core/dda_ctrl.sv
rtl/core/dda_dash_dot_line_stepper.sv
verif/dda_point_checker.sv
verif/tb_dda_dash_dot_line_stepper.sv
